>>> hdl/fpc_pkg.sv
// Package for the Fitch parsimony cost block.
// Holds operation codes, fixed field widths and the stack command and status types.
// No dependencies.
package fpc_pkg;

  localparam int VEC_W  = 64;
  localparam int COST_W = 16;
  localparam int CFG_W  = 5;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0]   OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0]   OP_COMBINE = 2'd1;
  localparam logic [OP_W-1:0]   OP_FINISH  = 2'd2;

  localparam logic [COST_W-1:0] COST_MAX   = 16'hFFFF;
  localparam logic [CFG_W-1:0]  SITES_RST  = 5'd16;

  typedef struct packed {
    logic push;
    logic combine;
    logic clear;
  } stk_cmd_t;

  typedef struct packed {
    logic lt_two;
    logic full;
  } stk_stat_t;

endpackage

>>> hdl/fitch_parsimony_cost.sv
// Fitch parsimony scorer over a stream of leaf, combine and finish transactions.
// Unless stalled, one input transaction is taken every cycle: the top two stack
// entries sit in registers and the memory's registered read, backed by a bypass
// register, keeps the third one ready, so a combine follows a combine with no
// bubble. One finish transaction gives one result; the input stalls only while
// two results wait at the output. The stack memory needs no clearing pass after
// reset. Depends on fpc_pkg, fpc_lane, fpc_merge and fpc_stack.
module fitch_parsimony_cost
  import fpc_pkg::*;
#(
  parameter int SITE_LANES  = 16,
  parameter int STATE_BITS  = 4,
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_sites_in_use,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [VEC_W-1:0]  in_leaf_states,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COST_W-1:0] out_parsimony_cost,
  output logic [VEC_W-1:0]  out_root_states,
  output logic              out_stack_error
);

  localparam int FIT_LANES = VEC_W / STATE_BITS;
  localparam int NL        = (SITE_LANES < FIT_LANES) ? SITE_LANES : FIT_LANES;
  localparam int USED_W    = NL * STATE_BITS;

  logic [CFG_W-1:0]  sites_r;
  logic [COST_W-1:0] cost_r, cost_nxt, merged_cost;
  logic              err_r, err_nxt;

  logic              in_acc, is_push, is_comb, is_fin;
  stk_cmd_t          cmd;
  stk_stat_t         stat;
  logic [VEC_W-1:0]  opnd_a, opnd_b, comb_vec, act_mask, stk_vec;
  logic [NL-1:0]     steps;

  logic              res_push, res_err;
  logic              out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt, skid_cost_r;
  logic [VEC_W-1:0]  out_root_r, out_root_nxt, skid_root_r;
  logic              out_err_r, out_err_nxt, skid_err_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sites_r <= SITES_RST;
    end else if (cfg_valid && cfg_ready) begin
      sites_r <= cfg_sites_in_use;
    end
  end

  genvar l;
  generate
    for (l = 0; l < NL; l++) begin : g_lane
      logic lane_on;
      assign lane_on = (sites_r > CFG_W'(l));
      assign act_mask[l*STATE_BITS +: STATE_BITS] = {STATE_BITS{lane_on}};
      fpc_lane #(.STATE_BITS(STATE_BITS)) u_lane (
        .active     (lane_on),
        .set_a      (opnd_a[l*STATE_BITS +: STATE_BITS]),
        .set_b      (opnd_b[l*STATE_BITS +: STATE_BITS]),
        .parent     (comb_vec[l*STATE_BITS +: STATE_BITS]),
        .union_step (steps[l])
      );
    end
    if (USED_W < VEC_W) begin : g_pad
      assign act_mask[VEC_W-1:USED_W] = '0;
      assign comb_vec[VEC_W-1:USED_W] = '0;
    end
  endgenerate

  fpc_merge #(.LANES(NL)) u_merge (
    .steps    (steps),
    .cost_in  (cost_r),
    .cost_out (merged_cost)
  );

  assign in_acc  = in_valid && in_ready;
  assign is_push = in_acc && (in_operation == OP_PUSH);
  assign is_comb = in_acc && (in_operation == OP_COMBINE);
  assign is_fin  = in_acc && (in_operation == OP_FINISH);

  assign cmd.push    = is_push;
  assign cmd.combine = is_comb;
  assign cmd.clear   = is_fin;
  assign stk_vec     = is_push ? (in_leaf_states & act_mask) : comb_vec;

  fpc_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .new_vec (stk_vec),
    .stat    (stat),
    .opnd_a  (opnd_a),
    .opnd_b  (opnd_b)
  );

  always_comb begin
    cost_nxt = cost_r;
    err_nxt  = err_r;
    if (is_push) begin
      err_nxt = err_r || stat.full;
    end else if (is_comb) begin
      cost_nxt = merged_cost;
      err_nxt  = err_r || stat.lt_two;
    end else if (is_fin) begin
      cost_nxt = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
      err_r  <= 1'b0;
    end else begin
      cost_r <= cost_nxt;
      err_r  <= err_nxt;
    end
  end

  assign res_push = is_fin;
  assign res_err  = err_r || stat.lt_two;
  assign in_ready = !skid_v_r;

  always_comb begin
    out_v_nxt    = out_v_r;
    out_cost_nxt = out_cost_r;
    out_root_nxt = out_root_r;
    out_err_nxt  = out_err_r;
    skid_v_nxt   = skid_v_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_nxt    = 1'b1;
        out_cost_nxt = skid_cost_r;
        out_root_nxt = skid_root_r;
        out_err_nxt  = skid_err_r;
        skid_v_nxt   = 1'b0;
      end else begin
        out_v_nxt    = res_push;
        out_cost_nxt = merged_cost;
        out_root_nxt = comb_vec;
        out_err_nxt  = res_err;
      end
    end else if (res_push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_cost_r <= out_cost_nxt;
    out_root_r <= out_root_nxt;
    out_err_r  <= out_err_nxt;
    if (res_push && out_v_r && !out_ready) begin
      skid_cost_r <= merged_cost;
      skid_root_r <= comb_vec;
      skid_err_r  <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_parsimony_cost = out_cost_r;
  assign out_root_states    = out_root_r;
  assign out_stack_error    = out_err_r;

endmodule

>>> hdl/fpc_lane.sv
// One site lane of the Fitch combine: intersection, or union with a step; an inactive lane gives zero.
// Depends on nothing but its parameter.
module fpc_lane #(
  parameter int STATE_BITS = 4
) (
  input  logic                  active,
  input  logic [STATE_BITS-1:0] set_a,
  input  logic [STATE_BITS-1:0] set_b,
  output logic [STATE_BITS-1:0] parent,
  output logic                  union_step
);

  logic [STATE_BITS-1:0] both;

  assign both       = set_a & set_b;
  assign union_step = active && (both == '0);

  always_comb begin
    if (!active) begin
      parent = '0;
    end else if (both == '0) begin
      parent = set_a | set_b;
    end else begin
      parent = both;
    end
  end

endmodule

>>> hdl/fpc_merge.sv
// Merging stage: counts the union steps of all lanes and adds them to the cost, saturating at COST_MAX.
// Depends on fpc_pkg.
module fpc_merge
  import fpc_pkg::*;
#(
  parameter int LANES = 16
) (
  input  logic [LANES-1:0]  steps,
  input  logic [COST_W-1:0] cost_in,
  output logic [COST_W-1:0] cost_out
);

  localparam int CNT_W = $clog2(LANES + 1);

  logic [CNT_W-1:0]  step_cnt;
  logic [COST_W:0]   cost_sum;

  always_comb begin
    step_cnt = '0;
    for (int l = 0; l < LANES; l++) begin
      step_cnt = step_cnt + CNT_W'(steps[l]);
    end
  end

  assign cost_sum = {1'b0, cost_in} + (COST_W+1)'(step_cnt);
  assign cost_out = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

endmodule

>>> hdl/fpc_stack.sv
// Vector stack: top two entries in registers, deeper entries in a memory whose
// registered read, with a bypass register, holds the third entry. Depends on fpc_pkg.
module fpc_stack
  import fpc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stk_cmd_t         cmd,
  input  logic [VEC_W-1:0] new_vec,
  output stk_stat_t        stat,
  output logic [VEC_W-1:0] opnd_a,
  output logic [VEC_W-1:0] opnd_b
);

  localparam int AW        = $clog2(STACK_DEPTH);
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [AW:0] SP_FULL = (AW+1)'(STACK_DEPTH);

  logic [VEC_W-1:0] mem [MEM_DEPTH];

  logic [AW:0]      sp_r, sp_nxt, sp_back;
  logic [VEC_W-1:0] top_r, top_nxt, sec_r, sec_nxt;
  logic [VEC_W-1:0] rd_r, byp_r, third;
  logic             byp_sel_r, byp_sel_nxt;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [AW:0]      sp_m2;

  assign stat.lt_two = (sp_r < (AW+1)'(2));
  assign stat.full   = (sp_r == SP_FULL);

  assign opnd_a = (sp_r != '0) ? top_r : '0;
  assign opnd_b = stat.lt_two ? '0 : sec_r;
  assign third  = byp_sel_r ? byp_r : rd_r;

  assign sp_m2   = sp_r - (AW+1)'(2);
  assign wr_addr = sp_m2[AW-1:0];
  assign sp_back = sp_nxt - (AW+1)'(3);
  assign rd_addr = sp_back[AW-1:0];

  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    sec_nxt = sec_r;
    wr_en   = 1'b0;
    if (cmd.clear) begin
      sp_nxt = '0;
    end else if (cmd.combine) begin
      top_nxt = new_vec;
      sec_nxt = third;
      sp_nxt  = stat.lt_two ? (AW+1)'(1) : sp_r - (AW+1)'(1);
    end else if (cmd.push && !stat.full) begin
      top_nxt = new_vec;
      sec_nxt = top_r;
      sp_nxt  = sp_r + (AW+1)'(1);
      wr_en   = !stat.lt_two;
    end
  end

  assign byp_sel_nxt = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= sec_r;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    sec_r <= sec_nxt;
    byp_r <= sec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= '0;
      byp_sel_r <= 1'b0;
    end else begin
      sp_r      <= sp_nxt;
      byp_sel_r <= byp_sel_nxt;
    end
  end

endmodule

>>> hdl/fpc_checker.sv
// Port-level checker for fitch_parsimony_cost, attached by the bind at the end.
// Depends on fpc_pkg.
module fpc_checker
  import fpc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   in_operation,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COST_W-1:0] out_parsimony_cost,
  input logic [VEC_W-1:0]  out_root_states,
  input logic              out_stack_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parsimony_cost) &&
      $stable(out_root_states) && $stable(out_stack_error))
    else $error("Result changed while stalled.");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result pending right after reset.");

  a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_operation == OP_FINISH))
    else $error("Result appeared without a finish transaction.");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input stalled with no result waiting.");

endmodule

bind fitch_parsimony_cost fpc_checker u_fpc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_operation       (in_operation),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_parsimony_cost (out_parsimony_cost),
  .out_root_states    (out_root_states),
  .out_stack_error    (out_stack_error)
);
